### hw/rtl/csr_pkg.sv
`timescale 1ns / 1ps
package csr_pkg;

    localparam int NUM_SOURCES    = 4;
    localparam int BUF_BYTES      = 256;
    localparam int MAX_MIDDLE_SEG = 48;
    localparam int NODE_LIMIT     = 3;
    localparam logic [7:0] BAD_CHAIN = 8'hff;

    localparam int LANES        = 8;
    localparam int LANE_SH      = $clog2(LANES);
    localparam int SRC_W        = 2;
    localparam int POS_W        = $clog2(BUF_BYTES + 1);
    localparam int ROWS_PER_SRC = (BUF_BYTES + LANES - 1) / LANES;
    localparam int MEM_ROWS     = NUM_SOURCES * ROWS_PER_SRC;
    localparam int ROW_W        = $clog2(MEM_ROWS);
    localparam int WCNT_W       = $clog2(ROWS_PER_SRC + 1);
    localparam int WIDX_W       = $clog2(ROWS_PER_SRC);

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] STATUS_DATA     = 2'd0;
    localparam logic [1:0] STATUS_BUFFERED = 2'd1;
    localparam logic [1:0] STATUS_REJECT   = 2'd2;

    typedef enum logic [1:0] {
        KIND_UNSEG  = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_MIDDLE = 2'd2,
        KIND_END    = 2'd3
    } seg_kind_t;

    typedef enum logic [1:0] {
        CMD_RESULT,
        CMD_STORE,
        CMD_FLUSH
    } cmd_op_t;

    typedef enum logic {
        BK_IDLE,
        BK_FLUSH
    } back_state_t;

    typedef struct packed {
        logic        extended_flag;
        logic [6:0]  source_node;
        logic [5:0]  dest_node;
        logic [1:0]  segment_kind;
        logic [7:0]  segment_number;
        logic [3:0]  byte_count;
        logic [63:0] frame_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  source;
        logic [63:0] payload;
        logic [3:0]  payload_bytes;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

    // One command from the front to the back part.
    typedef struct packed {
        cmd_op_t          op;
        logic [SRC_W-1:0] src;
        logic [POS_W-1:0] pos;
        logic [3:0]       nbytes;
        logic [POS_W-1:0] total;
        logic [63:0]      data;
        out_item_t        res;
    } cmd_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] mask;
        for (int l = 0; l < LANES; l++) begin
            mask[8*l +: 8] = (4'(l) < n) ? 8'hff : 8'h00;
        end
        return mask;
    endfunction

endpackage

### hw/rtl/csr_front.sv
`timescale 1ns / 1ps
module csr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    output logic              frame_stall,
    input  csr_pkg::in_item_t frame,
    output logic              push,
    output csr_pkg::cmd_t     push_cmd,
    input  logic              q_full
);
    import csr_pkg::*;

    logic [POS_W-1:0] stored_reg [NUM_SOURCES];
    logic [POS_W-1:0] stored_next [NUM_SOURCES];
    logic [7:0]       prev_reg [NUM_SOURCES];
    logic [7:0]       prev_next [NUM_SOURCES];

    logic             accept;
    logic             src_ok;
    logic             dst_ok;
    logic             len_ok;
    logic             base_ok;
    logic             mid_ok;
    logic [SRC_W-1:0] src;
    logic [POS_W-1:0] cur_stored;
    logic [7:0]       cur_prev;
    logic [7:0]       exp_seg;
    logic [POS_W:0]   fill_plus8;
    logic [POS_W:0]   fill_plus_len;

    assign frame_stall = q_full;
    assign accept      = frame_valid && !q_full;
    assign push        = accept;

    assign src_ok  = (frame.source_node <= 7'(NODE_LIMIT)) &&
                     (frame.source_node < 7'(NUM_SOURCES));
    assign dst_ok  = frame.dest_node <= 6'(NODE_LIMIT);
    assign len_ok  = (frame.byte_count != 4'd0) && (frame.byte_count <= 4'(LANES));
    assign base_ok = frame.extended_flag && src_ok && dst_ok && len_ok;
    assign src     = src_ok ? frame.source_node[SRC_W-1:0] : '0;

    assign cur_stored    = stored_reg[src];
    assign cur_prev      = prev_reg[src];
    assign exp_seg       = cur_prev + 8'd1;
    assign fill_plus8    = {1'b0, cur_stored} + (POS_W+1)'(LANES);
    assign fill_plus_len = {1'b0, cur_stored} + (POS_W+1)'(frame.byte_count);

    assign mid_ok = (exp_seg == frame.segment_number) &&
                    (frame.byte_count == 4'(LANES)) &&
                    (frame.segment_number >= 8'd1) &&
                    (frame.segment_number <= 8'(MAX_MIDDLE_SEG));

    always_comb
    begin
        stored_next = stored_reg;
        prev_next   = prev_reg;

        push_cmd.op                = CMD_RESULT;
        push_cmd.src               = src;
        push_cmd.pos               = cur_stored;
        push_cmd.nbytes            = frame.byte_count;
        push_cmd.total             = fill_plus_len[POS_W-1:0];
        push_cmd.data              = frame.frame_data;
        push_cmd.res.source        = src;
        push_cmd.res.payload       = '0;
        push_cmd.res.payload_bytes = '0;
        push_cmd.res.status        = STATUS_REJECT;
        push_cmd.res.last          = 1'b1;

        if (base_ok)
        begin
            unique case (seg_kind_t'(frame.segment_kind))
                KIND_UNSEG:
                begin
                    push_cmd.res.status        = STATUS_DATA;
                    push_cmd.res.payload       = frame.frame_data &
                                                 byte_mask(frame.byte_count);
                    push_cmd.res.payload_bytes = frame.byte_count;
                end
                KIND_FIRST:
                begin
                    if ((frame.segment_number == 8'd0) &&
                        (frame.byte_count == 4'(LANES)))
                    begin
                        push_cmd.op         = CMD_STORE;
                        push_cmd.pos        = '0;
                        push_cmd.res.status = STATUS_BUFFERED;
                        if (accept)
                        begin
                            stored_next[src] = POS_W'(LANES);
                            prev_next[src]   = 8'd0;
                        end
                    end
                end
                KIND_MIDDLE:
                begin
                    // A broken sequence poisons the chain until the next first segment.
                    if (!mid_ok)
                    begin
                        if (accept)
                        begin
                            prev_next[src] = BAD_CHAIN;
                        end
                    end
                    else if (fill_plus8 <= (POS_W+1)'(BUF_BYTES))
                    begin
                        push_cmd.op         = CMD_STORE;
                        push_cmd.res.status = STATUS_BUFFERED;
                        if (accept)
                        begin
                            stored_next[src] = fill_plus8[POS_W-1:0];
                            prev_next[src]   = frame.segment_number;
                        end
                    end
                end
                KIND_END:
                begin
                    if ((frame.segment_number == 8'd0) && (cur_prev != BAD_CHAIN) &&
                        (fill_plus_len <= (POS_W+1)'(BUF_BYTES)))
                    begin
                        push_cmd.op = CMD_FLUSH;
                        if (accept)
                        begin
                            stored_next[src] = fill_plus_len[POS_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SOURCES; s++)
            begin
                stored_reg[s] <= '0;
                prev_reg[s]   <= '0;
            end
        end
        else
        begin
            stored_reg <= stored_next;
            prev_reg   <= prev_next;
        end
    end

endmodule

### hw/rtl/csr_queue.sv
`timescale 1ns / 1ps
module csr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  csr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output csr_pkg::cmd_t pop_cmd,
    output logic          not_empty
);
    import csr_pkg::*;

    cmd_t              buf_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] wptr_next;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W-1:0] rptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = count_reg == QCNT_W'(Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_cmd   = buf_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/csr_back.sv
`timescale 1ns / 1ps
module csr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  csr_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               result_valid,
    input  logic               result_stall,
    output csr_pkg::out_item_t result
);
    import csr_pkg::*;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [SRC_W-1:0]  src_reg;
    logic [SRC_W-1:0]  src_next;
    logic [POS_W-1:0]  total_reg;
    logic [POS_W-1:0]  total_next;
    logic [WCNT_W-1:0] words_reg;
    logic [WCNT_W-1:0] words_next;
    logic [WCNT_W-1:0] issue_reg;
    logic [WCNT_W-1:0] issue_next;
    logic [WIDX_W-1:0] rd_word_reg;
    logic [WIDX_W-1:0] rd_word_next;
    logic              rd_pending_reg;
    logic              rd_pending_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_item_reg;
    out_item_t         out_item_next;

    logic [7:0]        mem [LANES][MEM_ROWS];
    logic [63:0]       rdata_reg;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en [LANES];
    logic [ROW_W-1:0]  wr_row [LANES];
    logic [7:0]        wr_byte [LANES];
    logic              store_op;

    logic              out_free;
    logic              consume;
    logic              last_word;
    logic [POS_W-1:0]  word_rem;
    logic [3:0]        word_bytes;

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    assign out_free   = !out_valid_reg || !result_stall;
    assign consume    = (state_reg == BK_FLUSH) && rd_pending_reg && out_free;
    assign word_rem   = total_reg - (POS_W'(rd_word_reg) << LANE_SH);
    assign word_bytes = (word_rem > POS_W'(LANES)) ? 4'(LANES) : word_rem[3:0];
    assign last_word  = (WCNT_W'(rd_word_reg) + WCNT_W'(1)) == words_reg;
    assign rd_row     = ROW_W'(src_reg) * ROW_W'(ROWS_PER_SRC) +
                        ROW_W'(issue_reg[WIDX_W-1:0]);

    always_comb
    begin
        state_next      = state_reg;
        src_next        = src_reg;
        total_next      = total_reg;
        words_next      = words_reg;
        issue_next      = issue_reg;
        rd_word_next    = rd_word_reg;
        rd_pending_next = rd_pending_reg;
        out_item_next   = out_item_reg;
        out_valid_next  = out_valid_reg && result_stall;
        q_pop           = 1'b0;
        store_op        = 1'b0;
        rd_en           = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.op == CMD_FLUSH)
                    begin
                        q_pop      = 1'b1;
                        store_op   = 1'b1;
                        src_next   = q_cmd.src;
                        total_next = q_cmd.total;
                        words_next = WCNT_W'(((POS_W+1)'(q_cmd.total) +
                                              (POS_W+1)'(LANES - 1)) >> LANE_SH);
                        issue_next = '0;
                        state_next = BK_FLUSH;
                    end
                    else if (out_free)
                    begin
                        q_pop          = 1'b1;
                        store_op       = q_cmd.op == CMD_STORE;
                        out_valid_next = 1'b1;
                        out_item_next  = q_cmd.res;
                    end
                end
            end
            BK_FLUSH:
            begin
                if (consume)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.source        = src_reg;
                    out_item_next.payload       = rdata_reg & byte_mask(word_bytes);
                    out_item_next.payload_bytes = word_bytes;
                    out_item_next.status        = STATUS_DATA;
                    out_item_next.last          = last_word;
                    rd_pending_next             = 1'b0;
                    if (last_word)
                    begin
                        state_next = BK_IDLE;
                    end
                end
                // The read register refills in the cycle its word moves to the output.
                if ((issue_reg < words_reg) && (!rd_pending_reg || consume))
                begin
                    rd_en           = 1'b1;
                    rd_pending_next = 1'b1;
                    rd_word_next    = issue_reg[WIDX_W-1:0];
                    issue_next      = issue_reg + 1'b1;
                end
            end
        endcase
    end

    // Each byte lane is its own memory, so an unaligned append writes every
    // lane at most once, possibly in two different rows.
    always_comb
    begin : wr_decode
        logic [LANE_SH-1:0] offs;
        logic [POS_W-1:0]   p;
        offs = '0;
        p    = '0;
        for (int l = 0; l < LANES; l++)
        begin
            offs       = LANE_SH'(l) - q_cmd.pos[LANE_SH-1:0];
            p          = q_cmd.pos + POS_W'(offs);
            wr_en[l]   = store_op && (4'(offs) < q_cmd.nbytes);
            wr_row[l]  = ROW_W'(q_cmd.src) * ROW_W'(ROWS_PER_SRC) + ROW_W'(p >> LANE_SH);
            wr_byte[l] = q_cmd.data[8*offs +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (wr_en[l])
            begin
                mem[l][wr_row[l]] <= wr_byte[l];
            end
        end
        if (rd_en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rdata_reg[8*l +: 8] <= mem[l][rd_row];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            words_reg      <= '0;
            issue_reg      <= '0;
            rd_word_reg    <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            words_reg      <= words_next;
            issue_reg      <= issue_next;
            rd_word_reg    <= rd_word_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        total_reg    <= total_next;
        out_item_reg <= out_item_next;
    end

    a_pending_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> (state_reg == BK_FLUSH))
        else $error("read data pending outside a flush");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_FLUSH) |-> (issue_reg <= words_reg))
        else $error("flush read index ran past the word count");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command popped from an empty queue");

    a_flush_has_words: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (q_cmd.op == CMD_FLUSH)) |=> (words_reg != '0))
        else $error("flush started with no words to send");

    a_last_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && last_word) |=> (state_reg == BK_IDLE && result.last))
        else $error("final flush word did not close the flush");

endmodule

### hw/rtl/can_segment_reassembly.sv
`timescale 1ns / 1ps
// CAN segment reassembly for four source nodes. Each accepted frame item yields
// exactly one result item, except a valid end segment, which yields the whole
// reassembled buffer as ceil(bytes/8) data items with last set on the final one.
// The front part checks the frame against its source's context and takes one
// frame a cycle while the two-entry command queue has room. The back part takes
// the queued commands in order; an end segment first appends its bytes, then the
// buffered words are read one at a time through the single read port of the
// byte-lane buffer memory and sent as data items, and no new command is taken
// until the last word is sent. The buffer memory needs no clearing after reset:
// only bytes that were written are ever read out.
module can_segment_reassembly (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    output logic               frame_stall,
    input  csr_pkg::in_item_t  frame,
    output logic               result_valid,
    input  logic               result_stall,
    output csr_pkg::out_item_t result
);
    import csr_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_pop;
    cmd_t q_cmd;
    logic q_valid;

    csr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .push        (push),
        .push_cmd    (push_cmd),
        .q_full      (q_full)
    );

    csr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (q_cmd),
        .not_empty (q_valid)
    );

    csr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
